>>> rtl/core/fir32q16_pkg.sv
// ----------------------------------------------------------------------------
// FIR filter package
// Widths, types and the fixed coefficient table shared by the FIR filter
// modules.
// ----------------------------------------------------------------------------
package fir32q16_pkg;

  // Filter geometry and number format.
  localparam int TAP_COUNT      = 32;
  localparam int FRACTION_BITS  = 16;
  localparam int SAMPLE_W       = 32;
  localparam int HUNDREDTHS_LEN = 32;

  // Coefficients are below one half in magnitude, so a sign bit and the
  // fraction bits hold them.
  localparam int COEF_W = FRACTION_BITS + 1;
  localparam int PROD_W = SAMPLE_W + COEF_W;
  localparam int TERM_W = PROD_W - FRACTION_BITS;
  localparam int ACC_W  = TERM_W + $clog2(TAP_COUNT);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

  // Limits of the signed output range.
  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // Coefficients in hundredths; the table repeats for longer filters.
  localparam int HUNDREDTHS [HUNDREDTHS_LEN] = '{
    1, 13, 2, -3,
    1, 2, 10, 5,
    5, 1, 3, 12,
    2, -40, -48, 13,
    1, 13, 2, 10,
    5, 5, 10, 5,
    5, 1, 3, 12,
    2, -40, -48, 13
  };

  // Fixed-point coefficient of a tap, truncated toward zero.
  function automatic coef_t coef_at(input int tap);
    longint scaled;
    scaled = (longint'(HUNDREDTHS[tap % HUNDREDTHS_LEN]) *
              (longint'(1) << FRACTION_BITS)) / 100;
    return coef_t'(scaled);
  endfunction

endpackage

>>> rtl/core/fir32q16_cell.sv
// ----------------------------------------------------------------------------
// FIR tap cell
// One tap of the transposed filter: multiplies the broadcast sample by its
// coefficient, rescales the product and adds the partial sum of its
// neighbour, holding the result for the next transaction.
// ----------------------------------------------------------------------------
module fir32q16_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  fir32q16_pkg::sample_t sample_i,
  input  fir32q16_pkg::coef_t   coef_i,
  input  fir32q16_pkg::acc_t    sum_i,
  output fir32q16_pkg::acc_t    sum_o
);
  import fir32q16_pkg::*;

  prod_t prod;
  acc_t  term;
  acc_t  sum_d;
  acc_t  sum_q;

  // Product, then an arithmetic shift right taken as a part-select so that
  // negative products round toward minus infinity.
  always_comb begin
    prod  = sample_i * coef_i;
    term  = {{(ACC_W-TERM_W){prod[PROD_W-1]}}, prod[PROD_W-1:FRACTION_BITS]};
    sum_d = sum_i + term;
  end

  // Partial sum advances once per accepted sample.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (en_i) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

>>> rtl/core/fir32q16_obuf.sv
// ----------------------------------------------------------------------------
// FIR output buffer
// Takes each finished sum from the head of the tap chain, queues it in an
// output register with a skid stage, and saturates it to 32 bits on the way
// out.
// ----------------------------------------------------------------------------
module fir32q16_obuf (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  fir32q16_pkg::acc_t    sum_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output fir32q16_pkg::sample_t filtered_out_o,
  output logic                  saturated_o
);
  import fir32q16_pkg::*;

  logic pend_q;
  logic pend_d;
  logic out_v_q;
  logic out_v_d;
  logic skid_v_q;
  logic skid_v_d;
  acc_t out_q;
  acc_t out_d;
  acc_t skid_q;
  acc_t skid_d;
  logic pop;
  logic push;
  logic [ACC_W-SAMPLE_W:0] high_bits;

  // A sum is pending in the head cell after each transaction.
  // It moves on whenever the two-entry queue has room.
  always_comb begin
    pop      = out_v_q & ~out_stall_i;
    push     = pend_q & (~skid_v_q | pop);
    pend_d   = load_i | (pend_q & ~push);
    out_v_d  = out_v_q;
    skid_v_d = skid_v_q;
    out_d    = out_q;
    skid_d   = skid_q;
    if (~out_v_q | pop) begin
      if (skid_v_q) begin
        out_d    = skid_q;
        out_v_d  = 1'b1;
        skid_d   = sum_i;
        skid_v_d = push;
      end else begin
        out_d   = sum_i;
        out_v_d = push;
      end
    end else if (push) begin
      skid_d   = sum_i;
      skid_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q   <= 1'b0;
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      pend_q   <= pend_d;
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  // New samples wait while the skid stage is occupied.
  assign in_stall_o  = skid_v_q;
  assign out_valid_o = out_v_q;

  // Saturate when the output sign bit and the bits above it do not all agree.
  always_comb begin
    high_bits   = out_q[ACC_W-1:SAMPLE_W-1];
    saturated_o = ~((&high_bits) | ~(|high_bits));
    if (saturated_o) begin
      filtered_out_o = out_q[ACC_W-1] ? SAMPLE_MIN : SAMPLE_MAX;
    end else begin
      filtered_out_o = out_q[SAMPLE_W-1:0];
    end
  end

endmodule

>>> rtl/core/fir_filter_32tap_q16_top.sv
// ----------------------------------------------------------------------------
// 32-tap FIR filter, Q16.16
// Transposed-form FIR filter with a fixed coefficient set and saturated
// output.
// ----------------------------------------------------------------------------
// The filter accepts one Q16.16 sample per clock cycle while in_stall_o is
// low and returns one filtered sample per transaction, in order, by way of
// the head cell register and the output register. It is built as a chain
// of 32 tap cells, each with its own multiplier and adder, which all update
// together on every accepted sample, so throughput is set by that single
// register stage and stays at one sample per cycle while the input is not
// stalled. An output register and a skid stage let a new sample enter while
// a result waits; the input stalls only when both are full. Reset clears
// every partial sum, the same as a sample history of all zeros. Sums beyond
// the signed 32-bit range are clamped and flagged on saturated_o.
module fir_filter_32tap_q16_top (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  fir32q16_pkg::sample_t sample_in_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output fir32q16_pkg::sample_t filtered_out_o,
  output logic                  saturated_o
);
  import fir32q16_pkg::*;

  logic in_acc;
  acc_t chain [TAP_COUNT+1];

  assign in_acc           = in_valid_i & ~in_stall_o;
  assign chain[TAP_COUNT] = '0;

  // Tap chain: partial sums move one cell toward the head per sample.
  for (genvar i = 0; i < TAP_COUNT; i++) begin : g_tap
    fir32q16_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (in_acc),
      .sample_i (sample_in_i),
      .coef_i   (coef_at(i)),
      .sum_i    (chain[i+1]),
      .sum_o    (chain[i])
    );
  end

  // Output queue and saturation.
  fir32q16_obuf u_obuf (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (in_acc),
    .sum_i          (chain[0]),
    .in_stall_o     (in_stall_o),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .filtered_out_o (filtered_out_o),
    .saturated_o    (saturated_o)
  );

endmodule

>>> rtl/core/fir32q16_checker.sv
// ----------------------------------------------------------------------------
// FIR filter checker
// Port-level assertions for the FIR filter top level, attached by bind.
// ----------------------------------------------------------------------------
module fir32q16_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input fir32q16_pkg::sample_t filtered_out_o,
  input logic                  saturated_o
);
  import fir32q16_pkg::*;

  // A stalled result transaction stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output valid dropped while stalled");

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(filtered_out_o) && $stable(saturated_o))
    else $error("output payload changed while stalled");

  // The input only stalls when results are queued behind the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result on offer");

  // A clamped result sits on one of the range limits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |->
      filtered_out_o == SAMPLE_MAX || filtered_out_o == SAMPLE_MIN)
    else $error("saturated result not at a range limit");

endmodule

bind fir_filter_32tap_q16_top fir32q16_checker u_fir32q16_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .filtered_out_o (filtered_out_o),
  .saturated_o    (saturated_o)
);

>>> verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// FIR filter testbench
// Feeds Q16.16 samples into the 32-tap filter. A short table of directed
// samples comes first, then random samples and sign-matched bursts that
// drive the sum into saturation. Each transaction is checked against an
// in-house model of the delay line, under several patterns of input gaps
// and output back-pressure.
// ----------------------------------------------------------------------------
module tb;

  import fir32q16_pkg::sample_t;
  import fir32q16_pkg::SAMPLE_MAX;
  import fir32q16_pkg::SAMPLE_MIN;

  localparam int NUM_TAPS      = 32;
  localparam int FRAC          = 16;
  localparam int RANDOM_ITEMS  = 1550;
  localparam int PHASE_ITEMS   = RANDOM_ITEMS / 3;
  localparam int HOLD_CYCLES   = 200;
  localparam int MAX_REPORTS   = 10;
  localparam int DRAIN_CYCLES  = 8;

  // Filter weights in hundredths of one.
  localparam int WEIGHT_CENTS [NUM_TAPS] = '{
    1, 13, 2, -3, 1, 2, 10, 5, 5, 1, 3, 12, 2, -40, -48, 13,
    1, 13, 2, 10, 5, 5, 10, 5, 5, 1, 3, 12, 2, -40, -48, 13
  };

  typedef struct packed {
    sample_t value;
    logic    sat;
  } filter_out_t;

  typedef struct {
    sample_t     sample;
    bit          typed;
    filter_out_t expected;
  } stim_row_t;

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    in_valid = 1'b0;
  logic    in_stall;
  sample_t sample_in = '0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  sample_t filtered_out;
  logic    saturated;

  // Model state: sample history, newest first, and the fixed weights.
  longint      history [NUM_TAPS];
  longint      weights [NUM_TAPS];
  filter_out_t pending_q [$];
  stim_row_t   directed_q [$];

  int mismatches = 0;
  int send_idle_pct = 19;
  int recv_stall_pct = 77;
  bit hold_request = 1'b0;
  int hold_left = 0;
  int burst_left = 0;
  bit burst_flip = 1'b0;

  fir_filter_32tap_q16_top u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .sample_in_i    (sample_in),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .filtered_out_o (filtered_out),
    .saturated_o    (saturated)
  );

  // Clock with a 12 ns period.
  initial begin
    forever #6 clk = ~clk;
  end

  // Clears the history and works out the weights, truncated toward zero.
  function automatic void reset_filter_model();
    int i;
    for (i = 0; i < NUM_TAPS; i++) begin
      history[i] = 0;
      weights[i] = (longint'(WEIGHT_CENTS[i]) * (longint'(1) << FRAC)) / 100;
    end
  endfunction

  // Shifts one sample into the history and forms the saturated weighted sum.
  function automatic filter_out_t filter_next(input sample_t s);
    int          i;
    longint      acc;
    filter_out_t r;
    acc = 0;
    for (i = NUM_TAPS - 1; i > 0; i--) history[i] = history[i-1];
    history[0] = longint'(s);
    for (i = 0; i < NUM_TAPS; i++) acc += (history[i] * weights[i]) >>> FRAC;
    if (acc > longint'(SAMPLE_MAX)) begin
      r.value = SAMPLE_MAX;
      r.sat   = 1'b1;
    end else if (acc < longint'(SAMPLE_MIN)) begin
      r.value = SAMPLE_MIN;
      r.sat   = 1'b1;
    end else begin
      r.value = sample_t'(acc);
      r.sat   = 1'b0;
    end
    return r;
  endfunction

  function automatic void add_row(input sample_t s, input bit typed,
                                  input sample_t value, input logic sat);
    stim_row_t row;
    row.sample         = s;
    row.typed          = typed;
    row.expected.value = value;
    row.expected.sat   = sat;
    directed_q.push_back(row);
  endfunction

  // Random samples: mostly bursts whose signs follow the weights, so that the
  // sum climbs to either limit, with plain noise in between.
  function automatic sample_t random_sample();
    int      kind;
    int      tap;
    sample_t mag;
    bit      negative;
    if (burst_left == 0 && $urandom_range(99) < 5) begin
      burst_left = NUM_TAPS;
      burst_flip = $urandom_range(1);
    end
    if (burst_left > 0) begin
      burst_left--;
      tap      = burst_left;
      mag      = sample_t'($urandom_range(32'h7FFF_FFFF, 32'h4000_0000));
      negative = burst_flip ^ (weights[tap] < 0);
      if (!negative) return mag;
      return ($urandom_range(3) == 0) ? SAMPLE_MIN : -mag;
    end
    kind = $urandom_range(9);
    case (kind)
      5, 6, 7: begin
        return sample_t'($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
      end
      8: begin
        case ($urandom_range(3))
          0: return SAMPLE_MAX;
          1: return SAMPLE_MIN;
          2: return '0;
          default: return '1;
        endcase
      end
      9: begin
        return sample_t'(32'd1 << $urandom_range(31));
      end
      default: begin
        return sample_t'($urandom);
      end
    endcase
  endfunction

  // Offers one sample, waits for the transaction and records what it should
  // produce. Entered and left at a falling edge.
  task automatic send_sample(input sample_t s, input bit typed,
                             input filter_out_t typed_result);
    filter_out_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    sample_in <= s;
    do @(posedge clk); while (in_stall);
    predicted = filter_next(s);
    pending_q.push_back(typed ? typed_result : predicted);
    @(negedge clk);
  endtask

  function automatic void report_field(input string field, input longint want,
                                       input longint got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch on %s: expected %0d, got %0d", field, want, got);
  endfunction

  // Output side: random stalls, or a long hold-off when one is asked for.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES - 1;
        out_stall    <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Each result transaction is compared with the oldest expectation.
  always @(posedge clk) begin
    filter_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        report_field("unexpected result", 0, longint'(filtered_out));
      end else begin
        want = pending_q.pop_front();
        if (filtered_out !== want.value)
          report_field("filtered_out", longint'(want.value), longint'(filtered_out));
        if (saturated !== want.sat)
          report_field("saturated", longint'(want.sat), longint'(saturated));
      end
    end
  end

  // Upper bound on the run time.
  initial begin
    #2_400_000;
    $display("Verification failed");
    $finish;
  end

  // Main sequence: reset, directed table, then three phases of random samples.
  initial begin
    int          n;
    filter_out_t none;
    none = '0;
    reset_filter_model();

    // Zero after reset, then one unit at tap 0 alone, then 22 full-scale
    // samples matching the weight signs, which must clamp at the top.
    add_row('0, 1'b1, '0, 1'b0);
    add_row(32'sh0001_0000, 1'b1, 32'sd655, 1'b0);
    for (n = 0; n < 22; n++) begin
      if (n == 7 || n == 8 || n == 18)
        add_row(SAMPLE_MIN, 1'b0, '0, 1'b0);
      else
        add_row(SAMPLE_MAX, n == 21, SAMPLE_MAX, 1'b1);
    end
    add_row('1, 1'b0, '0, 1'b0);

    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (directed_q[i])
      send_sample(directed_q[i].sample, directed_q[i].typed, directed_q[i].expected);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == PHASE_ITEMS) begin
        send_idle_pct  = 77;
        recv_stall_pct = 19;
      end else if (n == 2 * PHASE_ITEMS) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 1'b1;
      end
      send_sample(random_sample(), 1'b0, none);
    end
    in_valid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_q.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
